// ===== rtl/core/hgj_pkg.sv =====
// Shared types and constants for the hash group-join pre-aggregation core.
`default_nettype none

package hgj_pkg;

    // Row operation carried in the input tuser
    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_DRAIN = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Result kind carried in the output tuser
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_MATCH = 2'd2,
        STAT_DONE  = 2'd3
    } status_t;

    // Control sequencer states
    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_PROBE,
        S_DRAIN,
        S_MUL1,
        S_MUL2,
        S_RESULT
    } state_t;

    // One hash table slot
    typedef struct packed {
        logic        used;
        logic        has_left;
        logic [31:0] key;
        logic [63:0] lsum;
        logic [31:0] rcount;
    } entry_t;

    // Multiplicative hash constant
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

endpackage

`default_nettype wire

// ===== rtl/core/hgj_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
`default_nettype none

module hgj_mul (
    input  wire logic        aclk,
    input  wire logic [31:0] mul_a,
    input  wire logic [31:0] mul_b,
    output logic      [63:0] mul_p
);

    logic [63:0] prod_reg;

    // One multiply per cycle, product ready the next cycle
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    assign mul_p = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hgj_table.sv =====
// Slot memory: one write port, one read port with registered read data.
`default_nettype none

module hgj_table #(
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire hgj_pkg::entry_t          wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output hgj_pkg::entry_t               rd_data
);

    hgj_pkg::entry_t mem [DEPTH];
    hgj_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hash_groupjoin_preaggregate_core.sv =====
// Top level of the hash group-join core: sequencer, slot memory and multiplier.
//
// Hash group-join with pre-aggregation over an open-addressed table of
// TABLE_SLOTS slots with linear probing, held in one single-port-read memory.
// Each input beat gives exactly one result beat. An add or count row is
// hashed in two passes through the shared 32x32 multiplier, then probes slot
// after slot from the home slot, then posts the result. A drain scans one
// slot per cycle from the cursor, then forms the 64x32 product from a low and
// a high half on the same multiplier. Clear sweeps the memory one slot a cycle.
// After reset the same sweep runs with s_tready low. A new beat is taken
// while the previous result still waits in the output register.
`default_nettype none

module hash_groupjoin_preaggregate_core #(
    parameter int TABLE_SLOTS = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beat
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] row_key, [63:32] row_value
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    // result beat
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [95:0] m_tdata,   // [31:0] out_key, [95:32] joined_sum
    output logic      [1:0]  m_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);

    hgj_pkg::state_t  state_reg, state_next;
    hgj_pkg::cmd_t    cmd_reg, cmd_next;
    logic [31:0]      key_reg, key_next;
    logic [31:0]      val_reg, val_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] probe_cnt_reg, probe_cnt_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic             sweep_cmd_reg, sweep_cmd_next;
    logic [31:0]      hold_key_reg, hold_key_next;
    logic [31:0]      hold_hi_reg, hold_hi_next;
    logic [31:0]      hold_cnt_reg, hold_cnt_next;
    logic [63:0]      prod_lo_reg, prod_lo_next;
    hgj_pkg::status_t res_status_reg, res_status_next;
    logic [31:0]      res_key_reg, res_key_next;
    logic [63:0]      res_sum_reg, res_sum_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [1:0]       m_status_reg;
    logic [31:0]      m_key_reg;
    logic [63:0]      m_sum_reg;

    logic             out_load;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    hgj_pkg::entry_t  mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    hgj_pkg::entry_t  mem_rdata;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      mul_p;
    hgj_pkg::entry_t  base;
    logic [IDX_W-1:0] addr_inc;
    logic             slot_match;

    hgj_table #(
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    hgj_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    // Next slot with wrap, and drain match test
    assign addr_inc   = (addr_reg == LAST_IDX) ? '0 : addr_reg + IDX_W'(1);
    assign slot_match = mem_rdata.used && mem_rdata.has_left && (mem_rdata.rcount != '0);
    assign out_load   = (state_reg == hgj_pkg::S_RESULT) && (!m_tvalid_reg || m_tready);

    // Sequencer: next state, memory and multiplier control
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        addr_next       = addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        cursor_next     = cursor_reg;
        sweep_cmd_next  = sweep_cmd_reg;
        hold_key_next   = hold_key_reg;
        hold_hi_next    = hold_hi_reg;
        hold_cnt_next   = hold_cnt_reg;
        prod_lo_next    = prod_lo_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_sum_next    = res_sum_reg;
        s_tready        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = '0;
        mem_raddr       = addr_reg;
        mul_a           = '0;
        mul_b           = '0;
        base            = mem_rdata;

        case (state_reg)
            hgj_pkg::S_SWEEP: begin
                // zero one slot a cycle
                mem_we = 1'b1;
                if (addr_reg == LAST_IDX) begin
                    cursor_next = '0;
                    addr_next   = '0;
                    if (sweep_cmd_reg) begin
                        sweep_cmd_next  = 1'b0;
                        res_status_next = hgj_pkg::STAT_OK;
                        res_key_next    = '0;
                        res_sum_next    = '0;
                        state_next      = hgj_pkg::S_RESULT;
                    end else begin
                        state_next = hgj_pkg::S_IDLE;
                    end
                end else begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end

            hgj_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next = hgj_pkg::cmd_t'(s_tuser);
                    key_next = s_tdata[31:0];
                    val_next = s_tdata[63:32];
                    case (hgj_pkg::cmd_t'(s_tuser))
                        hgj_pkg::CMD_ADD, hgj_pkg::CMD_COUNT: begin
                            mul_a      = s_tdata[31:0];
                            mul_b      = hgj_pkg::HASH_MULT;
                            state_next = hgj_pkg::S_HASH1;
                        end
                        hgj_pkg::CMD_DRAIN: begin
                            if (cursor_reg == SLOTS_CNT) begin
                                res_status_next = hgj_pkg::STAT_DONE;
                                res_key_next    = '0;
                                res_sum_next    = '0;
                                state_next      = hgj_pkg::S_RESULT;
                            end else begin
                                mem_raddr  = cursor_reg[IDX_W-1:0];
                                addr_next  = cursor_reg[IDX_W-1:0];
                                state_next = hgj_pkg::S_DRAIN;
                            end
                        end
                        default: begin
                            addr_next      = '0;
                            sweep_cmd_next = 1'b1;
                            state_next     = hgj_pkg::S_SWEEP;
                        end
                    endcase
                end
            end

            hgj_pkg::S_HASH1: begin
                // scale the 32-bit hash onto the slot range
                mul_a      = mul_p[31:0];
                mul_b      = 32'(TABLE_SLOTS);
                state_next = hgj_pkg::S_HASH2;
            end

            hgj_pkg::S_HASH2: begin
                mem_raddr      = mul_p[32 +: IDX_W];
                addr_next      = mul_p[32 +: IDX_W];
                probe_cnt_next = CNT_W'(1);
                state_next     = hgj_pkg::S_PROBE;
            end

            hgj_pkg::S_PROBE: begin
                if (!mem_rdata.used || (mem_rdata.key == key_reg)) begin
                    // free slot takes the key, or key found: update in place
                    if (!mem_rdata.used) begin
                        base.used     = 1'b1;
                        base.has_left = 1'b0;
                        base.key      = key_reg;
                        base.lsum     = '0;
                        base.rcount   = '0;
                    end
                    mem_wdata = base;
                    if (cmd_reg == hgj_pkg::CMD_ADD) begin
                        mem_wdata.lsum     = base.lsum + {{32{val_reg[31]}}, val_reg};
                        mem_wdata.has_left = 1'b1;
                    end else if (base.rcount != '1) begin
                        mem_wdata.rcount = base.rcount + 32'd1;
                    end
                    mem_we          = 1'b1;
                    res_status_next = hgj_pkg::STAT_OK;
                    res_key_next    = '0;
                    res_sum_next    = '0;
                    state_next      = hgj_pkg::S_RESULT;
                end else if (probe_cnt_reg == SLOTS_CNT) begin
                    res_status_next = hgj_pkg::STAT_FULL;
                    res_key_next    = '0;
                    res_sum_next    = '0;
                    state_next      = hgj_pkg::S_RESULT;
                end else begin
                    mem_raddr      = addr_inc;
                    addr_next      = addr_inc;
                    probe_cnt_next = probe_cnt_reg + CNT_W'(1);
                end
            end

            hgj_pkg::S_DRAIN: begin
                if (slot_match) begin
                    hold_key_next = mem_rdata.key;
                    hold_hi_next  = mem_rdata.lsum[63:32];
                    hold_cnt_next = mem_rdata.rcount;
                    mul_a         = mem_rdata.lsum[31:0];
                    mul_b         = mem_rdata.rcount;
                    cursor_next   = CNT_W'(addr_reg) + CNT_W'(1);
                    state_next    = hgj_pkg::S_MUL1;
                end else if (addr_reg == LAST_IDX) begin
                    cursor_next     = SLOTS_CNT;
                    res_status_next = hgj_pkg::STAT_DONE;
                    res_key_next    = '0;
                    res_sum_next    = '0;
                    state_next      = hgj_pkg::S_RESULT;
                end else begin
                    mem_raddr = addr_reg + IDX_W'(1);
                    addr_next = addr_reg + IDX_W'(1);
                end
            end

            hgj_pkg::S_MUL1: begin
                // low half product ready, start high half
                prod_lo_next = mul_p;
                mul_a        = hold_hi_reg;
                mul_b        = hold_cnt_reg;
                state_next   = hgj_pkg::S_MUL2;
            end

            hgj_pkg::S_MUL2: begin
                res_sum_next    = prod_lo_reg + {mul_p[31:0], 32'd0};
                res_key_next    = hold_key_reg;
                res_status_next = hgj_pkg::STAT_MATCH;
                state_next      = hgj_pkg::S_RESULT;
            end

            hgj_pkg::S_RESULT: begin
                if (out_load) begin
                    state_next = hgj_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = hgj_pkg::S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hgj_pkg::S_SWEEP;
            addr_reg      <= '0;
            probe_cnt_reg <= '0;
            cursor_reg    <= '0;
            sweep_cmd_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            probe_cnt_reg <= probe_cnt_next;
            cursor_reg    <= cursor_next;
            sweep_cmd_reg <= sweep_cmd_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        hold_key_reg   <= hold_key_next;
        hold_hi_reg    <= hold_hi_next;
        hold_cnt_reg   <= hold_cnt_next;
        prod_lo_reg    <= prod_lo_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_sum_reg    <= res_sum_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_key_reg    <= res_key_reg;
            m_sum_reg    <= res_sum_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_sum_reg, m_key_reg};

    // Drain cursor never goes beyond one past the last slot
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= SLOTS_CNT)
        else $error("drain cursor beyond table");

    // Probe count is nonzero and bounded while probing
    a_probe_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hgj_pkg::S_PROBE) |-> (probe_cnt_reg != '0 && probe_cnt_reg <= SLOTS_CNT))
        else $error("probe count out of range");

    // An emitted match always advances the cursor past slot zero
    a_match_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_status_reg == hgj_pkg::STAT_MATCH) |-> (cursor_reg != '0))
        else $error("match emitted without cursor advance");

    // One beat in flight: no second accept right after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat accepted while busy");

    // Memory is written only during sweep or a probe hit
    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == hgj_pkg::S_SWEEP || state_reg == hgj_pkg::S_PROBE))
        else $error("unexpected slot write");

endmodule

`default_nettype wire

// ===== verif/hgj_join_checker.sv =====
// Checker for the hash group-join core: table prediction and result comparison.
module hgj_join_checker #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [63:0]       s_tdata,    // [31:0] row_key, [63:32] row_value
    input  logic [1:0]        s_tuser,    // [1:0] cmd
    // result channel
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [95:0]       m_tdata,    // [31:0] out_key, [95:32] joined_sum
    input  logic [1:0]        m_tuser,    // [1:0] status
    // to the testbench top
    output int unsigned       due_count,
    output int unsigned       error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PRINT_CAP = 100;

    typedef struct packed {
        hgj_pkg::status_t status;
        logic [31:0]      key;
        logic [63:0]      sum;
    } join_result_t;

    // Shadow copy of the hash table
    logic [31:0] tbl_key   [TABLE_SLOTS];
    bit          tbl_used  [TABLE_SLOTS];
    bit          tbl_left  [TABLE_SLOTS];
    logic [63:0] tbl_sum   [TABLE_SLOTS];
    logic [31:0] tbl_count [TABLE_SLOTS];
    int unsigned scan_pos;

    // Results owed by the core, oldest first
    join_result_t join_results_due[$];
    int unsigned  result_idx;

    task automatic report_mismatch(string msg);
        if (error_count < PRINT_CAP) begin
            $display("ERROR: result %0d: %s", result_idx, msg);
        end
        error_count++;
    endtask

    // Apply one row to the shadow table and return the result it causes
    function automatic join_result_t apply_row(hgj_pkg::cmd_t op, logic [31:0] key,
                                               logic [31:0] value);
        join_result_t res;
        logic [31:0]  hashed;
        logic [63:0]  hash_prod;
        int unsigned  idx;
        int unsigned  n;
        bit           hit;
        bit           found;
        res.status = hgj_pkg::STAT_OK;
        res.key    = '0;
        res.sum    = '0;
        hit        = 1'b0;
        found      = 1'b0;
        case (op)
            hgj_pkg::CMD_ADD, hgj_pkg::CMD_COUNT: begin
                // home slot is the top bits of the scaled multiplicative hash
                hashed    = key * hgj_pkg::HASH_MULT;
                hash_prod = {32'd0, hashed} * 64'(TABLE_SLOTS);
                idx       = hash_prod[63:32];
                // linear probe with wrap
                for (n = 0; n < TABLE_SLOTS && !hit; n++) begin
                    if (!tbl_used[idx]) begin
                        hit = 1'b1;
                    end else if (tbl_key[idx] == key) begin
                        hit   = 1'b1;
                        found = 1'b1;
                    end else begin
                        idx = (idx + 1 == TABLE_SLOTS) ? 0 : idx + 1;
                    end
                end
                if (!hit) begin
                    res.status = hgj_pkg::STAT_FULL;
                end else begin
                    if (!found) begin
                        tbl_used[idx]  = 1'b1;
                        tbl_left[idx]  = 1'b0;
                        tbl_key[idx]   = key;
                        tbl_sum[idx]   = '0;
                        tbl_count[idx] = '0;
                    end
                    if (op == hgj_pkg::CMD_ADD) begin
                        tbl_sum[idx]  = tbl_sum[idx] + {{32{value[31]}}, value};
                        tbl_left[idx] = 1'b1;
                    end else if (tbl_count[idx] != 32'hFFFF_FFFF) begin
                        // count saturates at all ones
                        tbl_count[idx] = tbl_count[idx] + 32'd1;
                    end
                end
            end
            hgj_pkg::CMD_DRAIN: begin
                // scan from the cursor for a slot seen on both sides
                res.status = hgj_pkg::STAT_DONE;
                while (scan_pos < TABLE_SLOTS && !hit) begin
                    if (tbl_used[scan_pos] && tbl_left[scan_pos] &&
                        tbl_count[scan_pos] != 32'd0) begin
                        hit        = 1'b1;
                        res.status = hgj_pkg::STAT_MATCH;
                        res.key    = tbl_key[scan_pos];
                        res.sum    = tbl_sum[scan_pos] * {32'd0, tbl_count[scan_pos]};
                    end
                    scan_pos++;
                end
            end
            hgj_pkg::CMD_CLEAR: begin
                for (n = 0; n < TABLE_SLOTS; n++) begin
                    tbl_used[n] = 1'b0;
                    tbl_left[n] = 1'b0;
                end
                scan_pos = 0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Watch both channels at the rising edge
    always @(posedge aclk) begin : watch_channels
        join_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                tbl_used[i] = 1'b0;
                tbl_left[i] = 1'b0;
            end
            scan_pos = 0;
            join_results_due.delete();
            result_idx  = 0;
            error_count = 0;
        end else begin
            // result beat against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (join_results_due.size() == 0) begin
                    report_mismatch($sformatf("status %0d with no result due", m_tuser));
                end else begin
                    want = join_results_due.pop_front();
                    if (m_tuser !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_tuser, want.status));
                    end
                    if (m_tdata[31:0] !== want.key) begin
                        report_mismatch($sformatf("out_key got %h want %h",
                                                  m_tdata[31:0], want.key));
                    end
                    if (m_tdata[95:32] !== want.sum) begin
                        report_mismatch($sformatf("joined_sum got %h want %h",
                                                  m_tdata[95:32], want.sum));
                    end
                end
                result_idx++;
            end
            // input beat: its result joins the tail of the queue
            if (s_tvalid && s_tready) begin
                join_results_due.insert(join_results_due.size(),
                                        apply_row(hgj_pkg::cmd_t'(s_tuser),
                                                  s_tdata[31:0], s_tdata[63:32]));
            end
        end
        due_count <= join_results_due.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the hash group-join testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_SLOTS = 1024;
    localparam int          IDLE_PCT    = 35;
    localparam int          RANDOM_ROWS = 420;
    localparam int          HOLD_CYCLES = 300;
    localparam int          TAIL_CYCLES = 2 * TABLE_SLOTS + 64;
    localparam longint      CYCLE_LIMIT = 6_000_000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;               // [31:0] row_key, [63:32] row_value
    logic [1:0]  s_tuser  = hgj_pkg::CMD_ADD; // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;                     // [31:0] out_key, [95:32] joined_sum
    logic [1:0]  m_tuser;                     // [1:0] status

    int unsigned due_count;
    int unsigned error_count;

    // idling controls for the two drivers, and the beat and cycle counters
    bit          tx_gaps   = 1'b1;
    bit          rx_gaps   = 1'b1;
    int unsigned hold_reqs = 0;
    int unsigned beats_sent = 0;
    longint      cycle_count = 0;

    hash_groupjoin_preaggregate_core #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hgj_join_checker #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .due_count   (due_count),
        .error_count (error_count)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result-side ready: random gaps, or a long hold when asked
    initial begin : rx_ready_drive
        int unsigned served;
        int unsigned hold_left;
        served = 0;
        forever begin
            @(negedge aclk);
            if (served != hold_reqs) begin
                served = hold_reqs;
                m_tready <= 1'b0;
                for (hold_left = HOLD_CYCLES; hold_left != 0; hold_left--) begin
                    @(negedge aclk);
                end
            end else if (rx_gaps) begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // offer one row beat and wait for it to be taken; starts and ends at a falling edge
    task automatic send_row(hgj_pkg::cmd_t op, logic [31:0] key, logic [31:0] value);
        if (tx_gaps) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {value, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        @(negedge aclk);
    endtask

    // stop offering until every owed result has come back
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (due_count != 0);
    endtask

    // word biased toward the sign and magnitude edges
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] key_pool [16];
        logic [31:0] base;
        int          episode;
        int          n_rows;
        int          n_drains;
        int          i;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty drain, edge keys and values, one-sided keys
        send_row(hgj_pkg::CMD_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_row(hgj_pkg::CMD_ADD,   32'h8000_0000, 32'h7FFF_FFFF);
        send_row(hgj_pkg::CMD_ADD,   32'h8000_0000, 32'h8000_0000);
        send_row(hgj_pkg::CMD_COUNT, 32'h8000_0000, 32'h0000_0000);
        send_row(hgj_pkg::CMD_COUNT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_row(hgj_pkg::CMD_COUNT, 32'h7FFF_FFFF, 32'h1234_5678);
        send_row(hgj_pkg::CMD_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_row(hgj_pkg::CMD_COUNT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_row(hgj_pkg::CMD_ADD,   32'h0000_0000, 32'h0000_0000);
        send_row(hgj_pkg::CMD_COUNT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_row(hgj_pkg::CMD_ADD,   32'h1234_5678, 32'h7FFF_FFFF);
        send_row(hgj_pkg::CMD_DRAIN, $urandom, $urandom);
        send_row(hgj_pkg::CMD_DRAIN, $urandom, $urandom);
        // right-only key gains a left side while a drain is under way
        send_row(hgj_pkg::CMD_ADD,   32'h7FFF_FFFF, 32'h8000_0000);
        send_row(hgj_pkg::CMD_DRAIN, $urandom, $urandom);
        send_row(hgj_pkg::CMD_DRAIN, $urandom, $urandom);
        send_row(hgj_pkg::CMD_DRAIN, $urandom, $urandom);
        // cursor stays at the end until a clear
        send_row(hgj_pkg::CMD_DRAIN, $urandom, $urandom);
        send_row(hgj_pkg::CMD_CLEAR, $urandom, $urandom);
        send_row(hgj_pkg::CMD_DRAIN, $urandom, $urandom);

        // random episodes: rows on a small key pool, then a run of drains
        for (i = 0; i < 16; i++) key_pool[i] = pick_word();
        episode = 0;
        base    = beats_sent;
        while (beats_sent < base + RANDOM_ROWS) begin
            episode++;
            tx_gaps = !(episode inside {[4:6]});
            rx_gaps = !(episode inside {[4:6]});
            if (episode == 5) begin
                // receiver stalls while rows keep coming
                hold_reqs++;
            end
            for (i = 0; i < 16; i++) begin
                if ($urandom_range(1)) key_pool[i] = pick_word();
            end
            n_rows = $urandom_range(24, 6);
            repeat (n_rows) begin
                if ($urandom_range(9) == 0) begin
                    send_row(hgj_pkg::cmd_t'($urandom_range(3)), $urandom, $urandom);
                end else begin
                    send_row($urandom_range(1) ? hgj_pkg::CMD_COUNT : hgj_pkg::CMD_ADD,
                             key_pool[$urandom_range(15)], pick_word());
                end
            end
            n_drains = $urandom_range(18, 2);
            repeat (n_drains) begin
                if ($urandom_range(4) == 0) begin
                    send_row($urandom_range(1) ? hgj_pkg::CMD_COUNT : hgj_pkg::CMD_ADD,
                             key_pool[$urandom_range(15)], pick_word());
                end
                send_row(hgj_pkg::CMD_DRAIN, $urandom, $urandom);
            end
            if ($urandom_range(2) == 0) send_row(hgj_pkg::CMD_CLEAR, $urandom, $urandom);
            if (episode == 8) pause_until_drained();
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // let every owed result arrive, then allow for late extras
        s_tvalid <= 1'b0;
        while (due_count != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (error_count == 0 && due_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
